// File: rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg: shared constants and functions for the color adjust pipeline
// Register codes, depth codes, divide-by-100 and the gamma constant tables.
// ----------------------------------------------------------------------------
package rca_pkg;

   localparam logic [1:0] CSR_SATURATION = 2'd0;
   localparam logic [1:0] CSR_GAMMA      = 2'd1;
   localparam logic [1:0] CSR_LUMINANCE  = 2'd2;
   localparam logic [1:0] CSR_DEPTH      = 2'd3;

   localparam logic [1:0] DEPTH_24 = 2'd1;
   localparam logic [1:0] DEPTH_30 = 2'd2;

   localparam logic [7:0]  PCT_UNITY  = 8'd100;
   localparam logic [15:0] GAMMA_TOP  = 16'd32767;
   localparam logic [15:0] CH_MAX     = 16'hFFFF;

   // ceil(2^32/100); exact floor(x/100) for x < 2^30
   localparam logic [25:0] RECIP_100 = 26'd42949673;
   // ceil(2^19/3); exact floor(x/3) for x < 2^19
   localparam logic [17:0] RECIP_3   = 18'd174763;

   typedef logic [15:0][29:0] fac_tab_type;

   function automatic logic [29:0] div100(input logic [29:0] x);
      logic [61:0] p;
      p = 62'(x) * 62'(RECIP_100);
      return p[32+:30];
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bt;
      x   = x_in;
      res = 64'd0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bt) begin
            x   = x - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [19:0] log2_q16(input logic [15:0] x);
      logic [3:0]  ip;
      logic [63:0] mant;
      logic [15:0] frac;
      ip   = 4'd0;
      frac = 16'd0;
      for (int i = 1; i < 16; i++) begin
         if ((x >> i) != 16'd0) ip = 4'(i);
      end
      mant = 64'(x) << (30 - ip);
      for (int k = 0; k < 16; k++) begin
         mant = (mant * mant) >> 30;
         frac = {frac[14:0], mant >= (64'd1 << 31)};
         if (mant >= (64'd1 << 31)) mant = mant >> 1;
      end
      return {ip, frac};
   endfunction

   // factors 2^(-2^-k) in Q30, k = 1..16
   function automatic fac_tab_type fac_table(input logic [63:0] seed);
      fac_tab_type tab;
      logic [63:0] fac;
      fac = isqrt64(seed);
      for (int j = 0; j < 16; j++) begin
         tab[j] = fac[29:0];
         fac    = isqrt64(fac << 30);
      end
      return tab;
   endfunction

   localparam logic [19:0]  LOG2_TOP = log2_q16(GAMMA_TOP);
   localparam fac_tab_type  EXP_FAC  = fac_table(64'd1 << 59);

endpackage

// File: rtl/rca_gamma.sv
// ----------------------------------------------------------------------------
// rca_gamma: one-channel gamma pipeline
// log2 by 16 squaring stages, scale by gamma/100, exp2 by 16 multiply stages.
// ----------------------------------------------------------------------------
module rca_gamma (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] c_in,
   input  logic [7:0]  pct,
   output logic        out_valid,
   output logic [15:0] c_out
);

   typedef enum logic [1:0] {
      GM_CALC,
      GM_PASS,
      GM_ZERO,
      GM_MAX
   } gmode_type;

   typedef struct packed {
      gmode_type   mode;
      logic [15:0] orig;
   } gtag_type;

   // entry stage
   gtag_type    tag0_in;
   logic [3:0]  ip0_in;
   logic [30:0] mant0_in;

   always_comb begin
      ip0_in = 4'd0;
      for (int i = 1; i < 15; i++) begin
         if (c_in[i]) ip0_in = 4'(i);
      end
      mant0_in = 31'(c_in) << (5'd30 - 5'(ip0_in));
      tag0_in.orig = c_in;
      if (pct == rca_pkg::PCT_UNITY || c_in > rca_pkg::GAMMA_TOP) begin
         tag0_in.mode = GM_PASS;
      end else if (c_in == 16'd0) begin
         tag0_in.mode = (pct == 8'd0) ? GM_MAX : GM_ZERO;
      end else begin
         tag0_in.mode = GM_CALC;
      end
   end

   logic        sq_vld_ff  [0:16];
   gtag_type    sq_tag_ff  [0:16];
   logic [3:0]  sq_ip_ff   [0:16];
   logic [30:0] sq_mant_ff [0:16];
   logic [15:0] sq_frac_ff [0:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= in_valid;
      end
      sq_tag_ff[0]  <= tag0_in;
      sq_ip_ff[0]   <= ip0_in;
      sq_mant_ff[0] <= mant0_in;
      sq_frac_ff[0] <= 16'd0;
   end

   // squaring stages: one fraction bit each
   for (genvar j = 0; j < 16; j++) begin : g_sq
      logic [61:0] sq_in;
      logic [31:0] s2_in;
      always_comb begin
         sq_in = 62'(sq_mant_ff[j]) * 62'(sq_mant_ff[j]);
         s2_in = sq_in[61:30];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j+1] <= 1'b0;
         end else begin
            sq_vld_ff[j+1] <= sq_vld_ff[j];
         end
         sq_tag_ff[j+1]  <= sq_tag_ff[j];
         sq_ip_ff[j+1]   <= sq_ip_ff[j];
         sq_mant_ff[j+1] <= s2_in[31] ? s2_in[31:1] : s2_in[30:0];
         sq_frac_ff[j+1] <= {sq_frac_ff[j][14:0], s2_in[31]};
      end
   end

   // distance from log2 of full scale, times gamma
   logic [19:0] lc_in, d_in;
   logic        dp_vld_ff;
   gtag_type    dp_tag_ff;
   logic [27:0] dp_ff;

   always_comb begin
      lc_in = {sq_ip_ff[16], sq_frac_ff[16]};
      d_in  = (rca_pkg::LOG2_TOP > lc_in) ? rca_pkg::LOG2_TOP - lc_in : 20'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_vld_ff <= 1'b0;
      end else begin
         dp_vld_ff <= sq_vld_ff[16];
      end
      dp_tag_ff <= sq_tag_ff[16];
      dp_ff     <= 28'(d_in) * 28'(pct);
   end

   // divide by 100; large exponents underflow to zero
   logic [29:0] m_in;
   gtag_type    mt_in;

   always_comb begin
      m_in  = rca_pkg::div100(30'(dp_ff));
      mt_in = dp_tag_ff;
      if (dp_tag_ff.mode == GM_CALC && m_in[21:16] >= 6'd20) mt_in.mode = GM_ZERO;
   end

   logic        ex_vld_ff  [0:16];
   gtag_type    ex_tag_ff  [0:16];
   logic [4:0]  ex_ip_ff   [0:16];
   logic [15:0] ex_frac_ff [0:16];
   logic [30:0] ex_res_ff  [0:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff[0] <= 1'b0;
      end else begin
         ex_vld_ff[0] <= dp_vld_ff;
      end
      ex_tag_ff[0]  <= mt_in;
      ex_ip_ff[0]   <= m_in[20:16];
      ex_frac_ff[0] <= m_in[15:0];
      ex_res_ff[0]  <= 31'd1 << 30;
   end

   // exp2 stages: fraction bit 15-j uses factor j
   for (genvar j = 0; j < 16; j++) begin : g_ex
      logic [60:0] pr_in;
      always_comb begin
         pr_in = 61'(ex_res_ff[j]) * 61'(rca_pkg::EXP_FAC[j]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ex_vld_ff[j+1] <= 1'b0;
         end else begin
            ex_vld_ff[j+1] <= ex_vld_ff[j];
         end
         ex_tag_ff[j+1]  <= ex_tag_ff[j];
         ex_ip_ff[j+1]   <= ex_ip_ff[j];
         ex_frac_ff[j+1] <= ex_frac_ff[j];
         ex_res_ff[j+1]  <= ex_frac_ff[j][15-j] ? pr_in[60:30] : ex_res_ff[j];
      end
   end

   // scale to full range, then shift by the integer exponent
   logic        v_vld_ff;
   gtag_type    v_tag_ff;
   logic [4:0]  v_ip_ff;
   logic [45:0] v_ff;
   logic        o_vld_ff;
   logic [15:0] o_ff;
   logic [15:0] o_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else begin
         v_vld_ff <= ex_vld_ff[16];
      end
      v_tag_ff <= ex_tag_ff[16];
      v_ip_ff  <= ex_ip_ff[16];
      v_ff     <= 46'(rca_pkg::GAMMA_TOP) * 46'(ex_res_ff[16]);
   end

   always_comb begin
      case (v_tag_ff.mode)
         GM_CALC: o_in = v_ff[45:30] >> v_ip_ff;
         GM_PASS: o_in = v_tag_ff.orig;
         GM_ZERO: o_in = 16'd0;
         default: o_in = rca_pkg::GAMMA_TOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= v_vld_ff;
      end
      o_ff <= o_in;
   end

   assign out_valid = o_vld_ff;
   assign c_out     = o_ff;

endmodule

// File: rtl/rgb_color_adjust_pack.sv
// ----------------------------------------------------------------------------
// rgb_color_adjust_pack: saturation, gamma, luminance and packing of a pixel
// rsp_valid strobes once for each accepted request, with the packed word in
// rsp_packed_color. Throughput one pixel per clock; busy is never raised.
// The gamma lanes use the 16-stage log2 and 16-stage exp2 pipelines.
// Synchronous reset clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module rgb_color_adjust_pack (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   output logic        rsp_valid,
   output logic [29:0] rsp_packed_color,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] sat_ff, gam_ff;
   logic [6:0] lum_ff;
   logic [1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff   <= rca_pkg::PCT_UNITY;
         gam_ff   <= rca_pkg::PCT_UNITY;
         lum_ff   <= 7'(rca_pkg::PCT_UNITY);
         depth_ff <= rca_pkg::DEPTH_24;
      end else if (csr_we) begin
         unique case (csr_index)
            rca_pkg::CSR_SATURATION: sat_ff   <= csr_wdata;
            rca_pkg::CSR_GAMMA:      gam_ff   <= csr_wdata;
            rca_pkg::CSR_LUMINANCE:  lum_ff   <= csr_wdata[6:0];
            rca_pkg::CSR_DEPTH:      depth_ff <= csr_wdata[1:0];
         endcase
      end
   end

   assign busy = 1'b0;

   // input word
   logic        v1_ff;
   logic [15:0] c1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      c1_ff[0] <= req_red_in;
      c1_ff[1] <= req_green_in;
      c1_ff[2] <= req_blue_in;
   end

   // channel sum
   logic        v2_ff;
   logic [17:0] sum2_ff;
   logic [15:0] c2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sum2_ff <= 18'(c1_ff[0]) + 18'(c1_ff[1]) + 18'(c1_ff[2]);
      c2_ff   <= c1_ff;
   end

   // gray = sum / 3 by reciprocal
   logic        v3_ff;
   logic [15:0] gray3_ff;
   logic [15:0] c3_ff [3];
   logic [35:0] g3_in;

   assign g3_in = 36'(sum2_ff) * 36'(rca_pkg::RECIP_3);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      gray3_ff <= g3_in[34:19];
      c3_ff    <= c2_ff;
   end

   // mix with gray
   logic        v4_ff;
   logic [24:0] mix4_ff [3];
   logic [6:0]  inv_in;

   assign inv_in = (sat_ff < rca_pkg::PCT_UNITY) ? 7'(rca_pkg::PCT_UNITY - sat_ff) : 7'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      for (int i = 0; i < 3; i++) begin
         mix4_ff[i] <= 25'(25'(c3_ff[i]) * 25'(sat_ff) + 25'(gray3_ff) * 25'(inv_in));
      end
   end

   // divide by 100 and clamp
   logic        v5_ff;
   logic [15:0] c5_ff [3];
   logic [29:0] q5_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) q5_in[i] = rca_pkg::div100(30'(mix4_ff[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      for (int i = 0; i < 3; i++) begin
         c5_ff[i] <= (q5_in[i] > 30'(rca_pkg::CH_MAX)) ? rca_pkg::CH_MAX : q5_in[i][15:0];
      end
   end

   // gamma lanes
   logic        gv [3];
   logic [15:0] gc [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rca_gamma u_gamma (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v5_ff),
         .c_in      (c5_ff[i]),
         .pct       (gam_ff),
         .out_valid (gv[i]),
         .c_out     (gc[i])
      );
   end

   // luminance
   logic        v6_ff;
   logic [22:0] lp6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= gv[0] & gv[1] & gv[2];
      end
      for (int i = 0; i < 3; i++) lp6_ff[i] <= 23'(gc[i]) * 23'(lum_ff);
   end

   logic        v7_ff;
   logic [15:0] c7_ff [3];
   logic [29:0] q7_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) q7_in[i] = rca_pkg::div100(30'(lp6_ff[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      for (int i = 0; i < 3; i++) begin
         c7_ff[i] <= (q7_in[i] > 30'(rca_pkg::CH_MAX)) ? rca_pkg::CH_MAX : q7_in[i][15:0];
      end
   end

   // pack
   logic        rv_ff;
   logic [29:0] pk_ff, pk_in;

   always_comb begin
      unique case (depth_ff)
         rca_pkg::DEPTH_30: pk_in = {c7_ff[0][15:6], c7_ff[1][15:6], c7_ff[2][15:6]};
         rca_pkg::DEPTH_24: pk_in = {6'd0, c7_ff[0][15:8], c7_ff[1][15:8], c7_ff[2][15:8]};
         default:           pk_in = 30'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v7_ff;
      end
      pk_ff <= pk_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_packed_color = pk_ff;

endmodule
